/* src/b64rle_pkg.sv */
// Shared types, constants and the character decode for the base64 span decoder.
// No dependencies; imported by b64rle_span_calc and base64_rle_span_decoder.
package b64rle_pkg;

    localparam int COORD_LIMIT_DEF = 1024;
    localparam int CFG_AW          = 3;
    localparam int CFG_DW          = 32;
    localparam int DIM_W           = 10;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 10'd320;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 10'd220;

    // register index = paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  len;
        logic [15:0] color;
        logic        past;
        logic        last;
    } t_span;

    typedef struct packed {
        logic  one;
        logic  two;
        t_span first;
        t_span second;
    } t_emit;

    function automatic logic [5:0] to_sextet(input logic [7:0] c);
        logic [5:0] s;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s = 6'd62;
        end else begin
            s = 6'd63;
        end
        return s;
    endfunction

endpackage

/* src/b64rle_span_calc.sv */
// Combinational group assembly and span split for one character.
// Depends on b64rle_pkg.
module b64rle_span_calc #(
    parameter int ROW_W   = 10,
    parameter int ROW_MAX = 1023
) (
    input  logic [7:0]                 i_char,
    input  logic                       i_start,
    input  logic [1:0]                 i_phase,
    input  logic [17:0]                i_held,
    input  logic [9:0]                 i_col,
    input  logic [ROW_W-1:0]           i_row,
    input  logic [9:0]                 i_frame_width,
    input  logic [9:0]                 i_frame_height,
    output logic [1:0]                 o_phase,
    output logic [17:0]                o_held,
    output logic [9:0]                 o_col,
    output logic [ROW_W-1:0]           o_row,
    output b64rle_pkg::t_emit          o_emit
);
    import b64rle_pkg::*;

    localparam int CW = (ROW_W > 10) ? ROW_W : 10;
    localparam logic [ROW_W-1:0] RMAX = ROW_W'(ROW_MAX);

    logic [5:0]       sext;
    logic [1:0]       ph;
    logic [17:0]      held;
    logic [9:0]       col;
    logic [ROW_W-1:0] row;
    logic [7:0]       rem, rem2, len1, len2;
    logic [15:0]      color;
    logic [9:0]       w, col0, avail1, col1;
    logic [ROW_W-1:0] row0, row1, row0_inc, row1_inc, row_wrap;
    logic [10:0]      sum1;
    logic             two;
    logic [CW-1:0]    row0_x, row1_x, fh_x;

    always_comb begin
        sext = to_sextet(i_char);
        ph   = i_start ? 2'd0 : i_phase;
        held = i_start ? 18'd0 : i_held;
        col  = i_start ? 10'd0 : i_col;
        row  = i_start ? '0 : i_row;

        rem   = {held[17:12], held[11:10]};
        color = {held[9:6], held[5:0], sext};
        w     = (i_frame_width == 10'd0) ? 10'd1 : i_frame_width;

        row_wrap = (row < RMAX) ? row + 1'b1 : RMAX;
        col0     = (col >= w) ? 10'd0 : col;
        row0     = (col >= w) ? row_wrap : row;
        row0_inc = (row0 < RMAX) ? row0 + 1'b1 : RMAX;

        avail1 = w - col0;
        len1   = ({2'b00, rem} < avail1) ? rem : avail1[7:0];
        sum1   = {1'b0, col0} + {3'b000, len1};
        col1   = (sum1 >= {1'b0, w}) ? 10'd0 : sum1[9:0];
        row1   = (sum1 >= {1'b0, w}) ? row0_inc : row0;
        row1_inc = (row1 < RMAX) ? row1 + 1'b1 : RMAX;

        rem2 = rem - len1;
        two  = (rem2 != 8'd0);
        len2 = ({2'b00, rem2} < w) ? rem2 : w[7:0];

        row0_x = CW'(row0);
        row1_x = CW'(row1);
        fh_x   = CW'(i_frame_height);

        o_emit.first.x      = col0;
        o_emit.first.y      = row0_x[9:0];
        o_emit.first.len    = len1;
        o_emit.first.color  = color;
        o_emit.first.past   = (row0_x >= fh_x);
        o_emit.first.last   = !two;
        o_emit.second.x     = 10'd0;
        o_emit.second.y     = row1_x[9:0];
        o_emit.second.len   = len2;
        o_emit.second.color = color;
        o_emit.second.past  = (row1_x >= fh_x);
        o_emit.second.last  = 1'b1;
        o_emit.one          = 1'b0;
        o_emit.two          = 1'b0;

        o_col = col;
        o_row = row;
        if (ph != PHASE_LAST) begin
            o_phase = ph + 2'd1;
            o_held  = {held[11:0], sext};
        end else begin
            o_phase = 2'd0;
            o_held  = 18'd0;
            if (rem != 8'd0) begin
                o_emit.one = 1'b1;
                o_emit.two = two;
                if (!two) begin
                    o_col = col1;
                    o_row = row1;
                end else if ({2'b00, len2} >= w) begin
                    o_col = 10'd0;
                    o_row = row1_inc;
                end else begin
                    o_col = {2'b00, len2};
                    o_row = row1;
                end
            end
        end
    end

endmodule

/* src/base64_rle_span_decoder.sv */
// Base64 run-length RGB565 span decoder, top level.
// Depends on b64rle_pkg and b64rle_span_calc.
//
// Input channel (i_in_valid / o_in_ready) takes one base64 character per
// transfer with a frame_start flag. Every fourth character closes a group
// that yields up to two spans on the output channel (o_out_valid /
// i_out_ready): x, y, length, RGB565 color, past-frame flag and a last-span
// mark. Groups with a zero count give no span.
// A character is registered at transfer, decoded from that input register,
// and its first span is registered into the output span register.
// Throughput: one character per cycle while the receiver keeps up. A group
// that splits at a row end gives its two spans on consecutive cycles when
// the receiver is ready; the second waits in a holding register, which
// drains before the next group can close, so the input does not stall.
// A stalled output keeps its spans; characters that do not close a group
// keep flowing, and a group-closing character that finds no room waits in
// the input register with o_in_ready low. Reset clears the position, the
// group and all valids and loads frame width 320 and frame height 220.
// Configure through the APB port (0x0 width, 0x4 height) only while idle; the block does not enforce this.
module base64_rle_span_decoder #(
    parameter int COORD_LIMIT = b64rle_pkg::COORD_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_code_char,
    input  logic                            i_frame_start,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [9:0]                      o_span_x,
    output logic [9:0]                      o_span_y,
    output logic [7:0]                      o_span_length,
    output logic [15:0]                     o_span_color,
    output logic                            o_past_frame,
    output logic                            o_last_span,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [b64rle_pkg::CFG_AW-1:0]   paddr,
    input  logic [b64rle_pkg::CFG_DW-1:0]   pwdata,
    output logic [b64rle_pkg::CFG_DW-1:0]   prdata,
    output logic                            pready
);
    import b64rle_pkg::*;

    localparam int ROW_W = $clog2(COORD_LIMIT);

    logic             r_a_valid, r_a_start;
    logic [7:0]       r_a_char;
    logic [1:0]       r_phase, n_phase;
    logic [17:0]      r_held, n_held;
    logic [9:0]       r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [9:0]       r_fw, r_fh;
    t_span            r_o, r_p;
    logic             r_o_valid, r_p_valid;
    t_emit            emit;
    logic             room, fire, take, cfg_wr;

    b64rle_span_calc #(
        .ROW_W   (ROW_W),
        .ROW_MAX (COORD_LIMIT - 1)
    ) u_calc (
        .i_char         (r_a_char),
        .i_start        (r_a_start),
        .i_phase        (r_phase),
        .i_held         (r_held),
        .i_col          (r_col),
        .i_row          (r_row),
        .i_frame_width  (r_fw),
        .i_frame_height (r_fh),
        .o_phase        (n_phase),
        .o_held         (n_held),
        .o_col          (n_col),
        .o_row          (n_row),
        .o_emit         (emit)
    );

    assign take       = r_o_valid && i_out_ready;
    assign room       = !r_p_valid && (!r_o_valid || i_out_ready);
    assign fire       = r_a_valid && (!emit.one || room);
    assign o_in_ready = !r_a_valid || fire;

    assign o_out_valid   = r_o_valid;
    assign o_span_x      = r_o.x;
    assign o_span_y      = r_o.y;
    assign o_span_length = r_o.len;
    assign o_span_color  = r_o.color;
    assign o_past_frame  = r_o.past;
    assign o_last_span   = r_o.last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = CFG_DW'(r_fw);
            REG_FRAME_HEIGHT: prdata = CFG_DW'(r_fh);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_phase   <= 2'd0;
            r_held    <= 18'd0;
            r_col     <= 10'd0;
            r_row     <= '0;
            r_fw      <= FRAME_WIDTH_RST;
            r_fh      <= FRAME_HEIGHT_RST;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_col   <= n_col;
                r_row   <= n_row;
            end
            if (fire && emit.one) begin
                r_o_valid <= 1'b1;
                r_p_valid <= emit.two;
            end else if (take) begin
                r_o_valid <= r_p_valid;
                r_p_valid <= 1'b0;
            end
            if (cfg_wr && paddr[2] == REG_FRAME_WIDTH) begin
                r_fw <= pwdata[9:0];
            end
            if (cfg_wr && paddr[2] == REG_FRAME_HEIGHT) begin
                r_fh <= pwdata[9:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_char  <= i_code_char;
            r_a_start <= i_frame_start;
        end
        if (fire && emit.one) begin
            r_o <= emit.first;
            r_p <= emit.second;
        end else if (take && r_p_valid) begin
            r_o <= r_p;
        end
    end

`ifndef SYNTH
    a_pend_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> r_o_valid)
        else $error("second span held without a first span");

    a_first_has_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_span) |-> r_p_valid)
        else $error("non-final span without a following span");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_span) |=> (o_out_valid && o_last_span))
        else $error("second span did not follow the first");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_span_length != 8'd0))
        else $error("zero-length span");
`endif

endmodule
